/* hw/rtl/cad_lbt_pkg.sv */
// Package: shared types and codes for the listen-before-talk sequencer.
package cad_lbt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CADS_PER_ATTEMPT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAD_TIMEOUT_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_BUDGET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_TICKS     = 3'd4;

	// Register reset values
	localparam logic [7:0]  CADS_PER_ATTEMPT_RST  = 8'd3;
	localparam logic [3:0]  MAX_ATTEMPTS_RST      = 4'd5;
	localparam logic [15:0] CAD_TIMEOUT_TICKS_RST = 16'd100;
	localparam logic [3:0]  TIMEOUT_BUDGET_RST    = 4'd3;
	localparam logic [15:0] BACKOFF_TICKS_RST     = 16'd500;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_CAD     = 2'd1,
		PH_BACKOFF = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_CAD     = 2'd1,
		CMD_RESTORE = 2'd2
	} radio_cmd_t;

	typedef struct packed {
		logic start_req;
		logic tick;
		logic cad_done;
		logic cad_detected;
	} lbt_in_t;

	typedef struct packed {
		logic [1:0] radio_command;
		logic       finished;
		logic       channel_clear;
		logic       busy_res;
	} lbt_out_t;

endpackage

/* hw/rtl/cad_listen_before_talk.sv */
// Listen-before-talk sequencer: CAD attempts, timeouts, backoff and verdict.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  item     | item_valid / item_stall | item   (start, tick, CAD flags)
//  result   | result_valid / stall    | result (command, verdict, busy)
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data (write only)
//
// One request per cycle while the result is not stalled; the request is
// captured in the input register, then one pass of next-state logic updates
// the sequencer state and loads the result register.
// Reset clears the sequencer to idle and loads the register defaults.
// A stalled result holds in the result register; the input register drains
// into it whenever it is empty or being taken, so a stall backs up one deep.
// cfg_ready is always high; writes take effect on the next cycle.
module cad_listen_before_talk
	import cad_lbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  lbt_in_t               item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output lbt_out_t              result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [7:0]  cads_per_attempt_q;
	logic [3:0]  max_attempts_q;
	logic [15:0] cad_timeout_ticks_q;
	logic [3:0]  timeout_budget_q;
	logic [15:0] backoff_ticks_q;

	// Sequencer state
	phase_t      phase_q, phase_d;
	logic [7:0]  cads_left_q, cads_left_d;
	logic [3:0]  timeouts_left_q, timeouts_left_d;
	logic [3:0]  attempts_left_q, attempts_left_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        passed_q, passed_d;

	// Pipeline registers
	logic        valid_s1;
	lbt_in_t     item_s1;
	logic        valid_s2;
	lbt_out_t    result_s2;
	lbt_out_t    result_d;

	logic        move_s1;
	logic        take_s2;
	logic [15:0] elapsed_inc;
	logic [15:0] elapsed_new;
	radio_cmd_t  cmd_d;

	assign cfg_ready = 1'b1;

	// The input register moves on when the result register is free or emptying.
	assign take_s2    = valid_s2 && !result_stall;
	assign move_s1    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !move_s1;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cads_per_attempt_q  <= CADS_PER_ATTEMPT_RST;
			max_attempts_q      <= MAX_ATTEMPTS_RST;
			cad_timeout_ticks_q <= CAD_TIMEOUT_TICKS_RST;
			timeout_budget_q    <= TIMEOUT_BUDGET_RST;
			backoff_ticks_q     <= BACKOFF_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CADS_PER_ATTEMPT:  cads_per_attempt_q  <= cfg_data[7:0];
				CFG_MAX_ATTEMPTS:      max_attempts_q      <= cfg_data[3:0];
				CFG_CAD_TIMEOUT_TICKS: cad_timeout_ticks_q <= cfg_data;
				CFG_TIMEOUT_BUDGET:    timeout_budget_q    <= cfg_data[3:0];
				CFG_BACKOFF_TICKS:     backoff_ticks_q     <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Saturating millisecond count
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

	// Next state and result for the request held in the input register
	always_comb begin
		phase_d         = phase_q;
		cads_left_d     = cads_left_q;
		timeouts_left_d = timeouts_left_q;
		attempts_left_d = attempts_left_q;
		elapsed_d       = elapsed_q;
		passed_d        = passed_q;
		cmd_d           = CMD_NONE;
		elapsed_new     = elapsed_q;
		result_d        = '0;

		unique case (phase_q)
			PH_CAD: begin
				if (item_s1.cad_done) begin
					// A finished CAD restarts the wait; any tick with it is dropped.
					if (item_s1.cad_detected) begin
						passed_d = 1'b0;
						phase_d  = PH_BACKOFF;
					end else if (cads_left_q <= 8'd1) begin
						cads_left_d = '0;
						passed_d    = 1'b1;
						phase_d     = PH_BACKOFF;
					end else begin
						cads_left_d = cads_left_q - 8'd1;
						elapsed_d   = '0;
						cmd_d       = CMD_CAD;
					end
				end else if (item_s1.tick) begin
					elapsed_new = elapsed_inc;
					elapsed_d   = elapsed_inc;
					if (elapsed_new >= cad_timeout_ticks_q) begin
						if (timeouts_left_q <= 4'd1) begin
							timeouts_left_d = '0;
							passed_d        = 1'b0;
							phase_d         = PH_BACKOFF;
						end else begin
							timeouts_left_d = timeouts_left_q - 4'd1;
							elapsed_d       = '0;
							cmd_d           = CMD_CAD;
						end
					end
				end
				// Attempt end: count it, restore the radio, start the backoff.
				if (phase_d == PH_BACKOFF) begin
					if (attempts_left_q != 4'd0) begin
						attempts_left_d = attempts_left_q - 4'd1;
					end
					elapsed_d = '0;
					cmd_d     = CMD_RESTORE;
				end
			end
			PH_BACKOFF: begin
				elapsed_new = item_s1.tick ? elapsed_inc : elapsed_q;
				elapsed_d   = elapsed_new;
				if (elapsed_new >= backoff_ticks_q) begin
					priority if (passed_q) begin
						result_d.finished      = 1'b1;
						result_d.channel_clear = 1'b1;
						phase_d                = PH_IDLE;
						elapsed_d              = '0;
					end else if (attempts_left_q == 4'd0) begin
						result_d.finished = 1'b1;
						phase_d           = PH_IDLE;
						elapsed_d         = '0;
					end else begin
						cads_left_d     = cads_per_attempt_q;
						timeouts_left_d = timeout_budget_q;
						elapsed_d       = '0;
						passed_d        = 1'b0;
						phase_d         = PH_CAD;
						cmd_d           = CMD_CAD;
					end
				end
			end
			default: begin
				// Idle: a start request loads the attempt count and opens attempt one.
				phase_d = PH_IDLE;
				if (item_s1.start_req) begin
					attempts_left_d = max_attempts_q;
					cads_left_d     = cads_per_attempt_q;
					timeouts_left_d = timeout_budget_q;
					elapsed_d       = '0;
					passed_d        = 1'b0;
					phase_d         = PH_CAD;
					cmd_d           = CMD_CAD;
				end
			end
		endcase

		result_d.radio_command = cmd_d;
		result_d.busy_res      = (phase_d != PH_IDLE);
	end

	// Sequencer state advances once per request leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			cads_left_q     <= '0;
			timeouts_left_q <= '0;
			attempts_left_q <= '0;
			elapsed_q       <= '0;
			passed_q        <= 1'b0;
		end else if (move_s1) begin
			phase_q         <= phase_d;
			cads_left_q     <= cads_left_d;
			timeouts_left_q <= timeouts_left_d;
			attempts_left_q <= attempts_left_d;
			elapsed_q       <= elapsed_d;
			passed_q        <= passed_d;
		end
	end

	// Valid bits of the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (take_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: capture on accept, hold while stalled
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (move_s1) begin
			result_s2 <= result_d;
		end
	end

endmodule

/* hw/rtl/cad_lbt_checker.sv */
// Checker: port-level properties of the listen-before-talk sequencer, bound to the top level.
module cad_lbt_checker
	import cad_lbt_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     result_valid,
	input logic     result_stall,
	input lbt_out_t result
);

	// A verdict of clear only comes with the end of a check.
	a_clear_needs_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.channel_clear |-> result.finished)
		else $error("channel_clear without finished");

	// A finished check leaves the sequencer idle.
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.finished |-> !result.busy_res)
		else $error("finished while still busy");

	// Any radio command belongs to an active check.
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.radio_command != CMD_NONE) |-> result.busy_res)
		else $error("radio command while idle");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind cad_listen_before_talk cad_lbt_checker u_cad_lbt_checker (.*);
